@@ hdl/sdqr_pkg.sv @@
// sdqr_pkg: shared types and constants of the signed divider
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package sdqr_pkg;

   localparam int FIELD_W = 64;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_DIV0 = 2'd1,
      ST_OVF  = 2'd2
   } status_type;

   // how the current transaction is finished
   typedef enum logic [1:0] {
      K_NORMAL = 2'd0,
      K_ZERO   = 2'd1,
      K_DIV0   = 2'd2,
      K_OVF    = 2'd3
   } kind_type;

   typedef struct packed {
      logic load;
      logic prep;
      logic step;
      logic fix;
   } dp_cmd_type;

   typedef struct packed {
      logic special;
   } dp_status_type;

endpackage

`default_nettype wire

@@ hdl/sdqr_if.sv @@
// sdqr_req_if, sdqr_rsp_if: valid/ready channels of the signed divider
// depends on sdqr_pkg
`timescale 1ns / 1ps
`default_nettype none

interface sdqr_req_if;
   import sdqr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] dividend;
   logic signed [FIELD_W-1:0] divisor;
   modport source (output valid, output dividend, output divisor, input ready);
   modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface sdqr_rsp_if;
   import sdqr_pkg::*;
   logic                      valid;
   logic                      ready;
   logic signed [FIELD_W-1:0] quotient;
   logic signed [FIELD_W-1:0] remainder;
   status_type                status;
   modport source (output valid, output quotient, output remainder, output status,
                   input ready);
   modport sink   (input valid, input quotient, input remainder, input status,
                   output ready);
endinterface

`default_nettype wire

@@ hdl/sdqr_ctrl.sv @@
// sdqr_ctrl: sequencing state machine of the signed divider
// depends on sdqr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdqr_ctrl #(
   parameter int DATA_WIDTH = 64
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  wire                      rsp_ready,
   input  sdqr_pkg::dp_status_type  dp_status,
   output sdqr_pkg::dp_cmd_type     dp_cmd
);
   import sdqr_pkg::*;

   localparam int CNT_W = $clog2(DATA_WIDTH);

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_PREP   = 4'b0010,
      S_ITER   = 4'b0100,
      S_FINISH = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dp_cmd       = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dp_cmd.load = 1'b1;
               state_in    = S_PREP;
            end
         end
         S_PREP: begin
            dp_cmd.prep = 1'b1;
            cnt_in      = CNT_W'(DATA_WIDTH - 1);
            state_in    = dp_status.special ? S_FINISH : S_ITER;
         end
         S_ITER: begin
            dp_cmd.step = 1'b1;
            cnt_in      = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               dp_cmd.fix   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_accept_prep: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_PREP)
      else $error("accepted transaction did not enter prep");

   a_prep_iter: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PREP && !dp_status.special
      |=> state_ff == S_ITER && cnt_ff == CNT_W'(DATA_WIDTH - 1))
      else $error("iteration not started with full count");

   a_iter_end: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ITER && cnt_ff == '0 |=> state_ff == S_FINISH)
      else $error("iteration did not end after last bit");

   a_fix_valid: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.fix |=> rsp_valid_ff)
      else $error("finished result not presented");

   a_fix_free: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.fix |-> out_free)
      else $error("result register overwritten before taken");

endmodule

`default_nettype wire

@@ hdl/sdqr_dp.sv @@
// sdqr_dp: operand, shift-subtract and result registers of the signed divider
// depends on sdqr_pkg
`timescale 1ns / 1ps
`default_nettype none

module sdqr_dp #(
   parameter int DATA_WIDTH = 64
) (
   input  wire                                  clock,
   input  wire  [sdqr_pkg::FIELD_W-1:0]         dividend,
   input  wire  [sdqr_pkg::FIELD_W-1:0]         divisor,
   input  sdqr_pkg::dp_cmd_type                 dp_cmd,
   output sdqr_pkg::dp_status_type              dp_status,
   output logic signed [sdqr_pkg::FIELD_W-1:0]  quotient,
   output logic signed [sdqr_pkg::FIELD_W-1:0]  remainder,
   output sdqr_pkg::status_type                 status
);
   import sdqr_pkg::*;

   localparam int W = DATA_WIDTH;
   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};

   logic [W-1:0]         a_ff, a_in, b_ff, b_in;
   logic [W-1:0]         dq_ff, dq_in, mb_ff, mb_in, r_ff, r_in;
   logic                 neg_a_ff, neg_a_in, neg_b_ff, neg_b_in;
   kind_type             kind_ff, kind_in, kind_new;
   logic [FIELD_W-1:0]   quot_ff, quot_in, rem_ff, rem_in;
   status_type           status_ff, status_in;
   logic [W:0]           r_shift, diff;
   logic [W-1:0]         q_fix, r_fix;

   always_comb begin
      if (b_ff == '0) begin
         kind_new = K_DIV0;
      end else if (a_ff == '0) begin
         kind_new = K_ZERO;
      end else if (a_ff == MOST_NEG && b_ff == '1) begin
         kind_new = K_OVF;
      end else begin
         kind_new = K_NORMAL;
      end
   end

   assign dp_status.special = (kind_new != K_NORMAL);

   assign r_shift = {r_ff, dq_ff[W-1]};
   assign diff    = r_shift - {1'b0, mb_ff};
   assign q_fix   = (neg_a_ff ^ neg_b_ff) ? W'(0) - dq_ff : dq_ff;
   assign r_fix   = neg_a_ff ? W'(0) - r_ff : r_ff;

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      neg_a_in  = neg_a_ff;
      neg_b_in  = neg_b_ff;
      kind_in   = kind_ff;
      dq_in     = dq_ff;
      mb_in     = mb_ff;
      r_in      = r_ff;
      quot_in   = quot_ff;
      rem_in    = rem_ff;
      status_in = status_ff;
      if (dp_cmd.load) begin
         a_in = dividend[W-1:0];
         b_in = divisor[W-1:0];
      end
      if (dp_cmd.prep) begin
         neg_a_in = a_ff[W-1];
         neg_b_in = b_ff[W-1];
         kind_in  = kind_new;
         dq_in    = a_ff[W-1] ? W'(0) - a_ff : a_ff;
         mb_in    = b_ff[W-1] ? W'(0) - b_ff : b_ff;
         r_in     = '0;
      end
      if (dp_cmd.step) begin
         if (!diff[W]) begin
            r_in  = diff[W-1:0];
            dq_in = {dq_ff[W-2:0], 1'b1};
         end else begin
            r_in  = r_shift[W-1:0];
            dq_in = {dq_ff[W-2:0], 1'b0};
         end
      end
      if (dp_cmd.fix) begin
         case (kind_ff)
            K_NORMAL: begin
               quot_in   = FIELD_W'($signed(q_fix));
               rem_in    = FIELD_W'($signed(r_fix));
               status_in = ST_OK;
            end
            K_OVF: begin
               quot_in   = FIELD_W'($signed(~MOST_NEG));
               rem_in    = '0;
               status_in = ST_OVF;
            end
            K_DIV0: begin
               quot_in   = '0;
               rem_in    = '0;
               status_in = ST_DIV0;
            end
            default: begin
               quot_in   = '0;
               rem_in    = '0;
               status_in = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      a_ff      <= a_in;
      b_ff      <= b_in;
      neg_a_ff  <= neg_a_in;
      neg_b_ff  <= neg_b_in;
      kind_ff   <= kind_in;
      dq_ff     <= dq_in;
      mb_ff     <= mb_in;
      r_ff      <= r_in;
      quot_ff   <= quot_in;
      rem_ff    <= rem_in;
      status_ff <= status_in;
   end

   assign quotient  = quot_ff;
   assign remainder = rem_ff;
   assign status    = status_ff;

endmodule

`default_nettype wire

@@ hdl/signed_divider_quotient_remainder_unit.sv @@
// signed_divider_quotient_remainder_unit: signed restoring divider, quotient and remainder
// depends on sdqr_pkg, sdqr_if, sdqr_ctrl, sdqr_dp
//
//   channel  dir  transaction
//   req_ch   in   dividend, divisor
//   rsp_ch   out  quotient, remainder, status
//
// operands load at the accept edge; a normal transaction then runs to its result through
// one sign/magnitude prep, DATA_WIDTH shift-subtract steps and one sign fix-up
// zero divisor, zero dividend and overflow skip the steps: prep, then fix-up
// one transaction at a time; the next is accepted once the fix-up is done
// a new transaction is accepted while the previous result waits on rsp_ch;
// the fix-up stalls until that result is taken
// reset is synchronous and clears only the controller
`timescale 1ns / 1ps
`default_nettype none

module signed_divider_quotient_remainder_unit #(
   parameter int DATA_WIDTH = 64
) (
   input  wire        clock,
   input  wire        reset,
   sdqr_req_if.sink   req_ch,
   sdqr_rsp_if.source rsp_ch
);
   import sdqr_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;

   sdqr_ctrl #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   sdqr_dp #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock     (clock),
      .dividend  (req_ch.dividend),
      .divisor   (req_ch.divisor),
      .dp_cmd    (dp_cmd),
      .dp_status (dp_status),
      .quotient  (rsp_ch.quotient),
      .remainder (rsp_ch.remainder),
      .status    (rsp_ch.status)
   );

endmodule

`default_nettype wire
